@@ rtl/cmf_pkg.sv @@
package cmf_pkg;

   localparam int PIXEL_W      = 32;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_INDEX_W  = 4;
   localparam int CSR_DATA_W   = 32;

   localparam int DEFAULT_MAX_WIDTH  = 1024;
   localparam int DEFAULT_MAX_HEIGHT = 4096;

   localparam int unsigned DEFAULT_FRAME_WIDTH  = 640;
   localparam int unsigned DEFAULT_FRAME_HEIGHT = 480;

   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = CSR_INDEX_W'(1);

   localparam logic FUNC_DRAIN = 1'b1;

   typedef logic signed [PIXEL_W-1:0] pixel_type;

   // last usable index of a dimension, zero acting as one and large values capped
   function automatic int unsigned clamp_last(input int unsigned value,
                                              input int unsigned max_value);
      int unsigned result;
      if (value == 0) begin
         result = 0;
      end else if (value > max_value) begin
         result = max_value - 1;
      end else begin
         result = value - 1;
      end
      return result;
   endfunction

endpackage

@@ rtl/cmf_req_if.sv @@
interface cmf_req_if import cmf_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      func;
   pixel_type pixel_in;

   modport source (output valid, output func, output pixel_in, input ready);
   modport sink (input valid, input func, input pixel_in, output ready);
endinterface

@@ rtl/cmf_rsp_if.sv @@
interface cmf_rsp_if import cmf_pkg::*; ();
   logic      valid;
   logic      ready;
   pixel_type pixel_out;
   logic      frame_end;

   modport source (output valid, output pixel_out, output frame_end, input ready);
   modport sink (input valid, input pixel_out, input frame_end, output ready);
endinterface

@@ rtl/cmf_csr_if.sv @@
interface cmf_csr_if import cmf_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/cross_median_filter.sv @@
// Streaming 5-point cross median over a raster frame of signed 32-bit pixels. Push beats
// (func 0) carry pixels in raster order; the result for a pixel of row r leaves when the
// same column of row r+1 is pushed, so the first row gives no results. After the last
// pixel of the frame, one drain beat (func 1) per column flushes the last row, and the
// final result carries frame_end. Neighbours outside the frame take the center value.
// One beat is accepted every clock unless output back-pressure stalls; registers follow
// the input stage (line-store reads and neighbour selection) and the median stage. Two
// line stores of MAX_WIDTH words hold the rows above; they need no clearing after reset.
// Writing frame_width or frame_height restarts the frame and should be done while idle.
module cross_median_filter import cmf_pkg::*; #(
   parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
   input  logic      clock,
   input  logic      reset,
   cmf_req_if.sink   req_bus,
   cmf_rsp_if.source rsp_bus,
   cmf_csr_if.sink   csr_bus
);

   localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;

   // line stores
   pixel_type center_mem [MAX_WIDTH];
   pixel_type upper_mem [MAX_WIDTH];
   pixel_type ctr_rd_ff, right_rd_ff, up_rd_ff;

   // position and geometry
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             flushing_ff, flushing_in;
   logic [COL_W-1:0] last_col_ff, last_col_in;
   logic [ROW_W-1:0] last_row_ff, last_row_in;
   pixel_type        left_ff, left_in;

   // bypass of the last line-store write
   logic             wr_vld_ff;
   logic [COL_W-1:0] wr_addr_ff;
   pixel_type        wr_pix_ff, wr_ctr_ff;

   // operand stage
   logic      s1_vld_ff, s1_vld_in;
   pixel_type s1_op_ff [5];
   logic      s1_end_ff;

   // result stage
   logic      out_vld_ff, out_vld_in;
   pixel_type out_pix_ff;
   logic      out_end_ff;

   logic             req_fire, is_drain, do_push, do_drain, gives_result;
   logic             col_last, row_last, has_up, csr_fire, restart, out_load;
   logic [COL_W-1:0] right_addr, rd_right_addr;
   pixel_type        ctr_val, right_mem, up_mem;
   pixel_type        op [5];
   pixel_type        median;
   logic [2:0]       rank [5];

   assign csr_bus.ready = 1'b1;
   assign csr_fire      = csr_bus.valid;

   assign out_load      = s1_vld_ff && (!out_vld_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_vld_ff || out_load;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign is_drain = req_bus.func == FUNC_DRAIN;
   assign do_push  = req_fire && !is_drain && !flushing_ff;
   assign do_drain = req_fire && is_drain && flushing_ff;

   assign col_last     = col_ff == last_col_ff;
   assign row_last     = row_ff == last_row_ff;
   assign gives_result = do_drain || (do_push && row_ff != '0);
   assign has_up       = flushing_ff ? (row_ff != '0) : (row_ff > ROW_W'(1));

   assign right_addr = col_ff + COL_W'(1);

   assign ctr_val   = (wr_vld_ff && wr_addr_ff == col_ff) ? wr_pix_ff : ctr_rd_ff;
   assign right_mem = (wr_vld_ff && wr_addr_ff == right_addr) ? wr_pix_ff : right_rd_ff;
   assign up_mem    = (wr_vld_ff && wr_addr_ff == col_ff) ? wr_ctr_ff : up_rd_ff;

   // operand order: center, up, down, left, right
   always_comb begin
      op[0] = ctr_val;
      op[1] = has_up ? up_mem : ctr_val;
      op[2] = flushing_ff ? ctr_val : req_bus.pixel_in;
      op[3] = (col_ff != '0) ? left_ff : ctr_val;
      op[4] = col_last ? ctr_val : right_mem;
   end

   // frame position
   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      flushing_in = flushing_ff;
      last_col_in = last_col_ff;
      last_row_in = last_row_ff;
      restart     = 1'b0;
      if (csr_fire) begin
         case (csr_bus.index)
            REG_FRAME_WIDTH: begin
               last_col_in = COL_W'(clamp_last(
                  32'(csr_bus.data[WIDTH_REG_W-1:0]), MAX_WIDTH));
               restart = 1'b1;
            end
            REG_FRAME_HEIGHT: begin
               last_row_in = ROW_W'(clamp_last(
                  32'(csr_bus.data[HEIGHT_REG_W-1:0]), MAX_HEIGHT));
               restart = 1'b1;
            end
            default: begin
            end
         endcase
      end else if (do_push) begin
         if (col_last) begin
            col_in = '0;
            if (row_last) begin
               flushing_in = 1'b1;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end else begin
            col_in = right_addr;
         end
      end else if (do_drain) begin
         if (col_last) begin
            restart = 1'b1;
         end else begin
            col_in = right_addr;
         end
      end
      if (restart) begin
         col_in      = '0;
         row_in      = '0;
         flushing_in = 1'b0;
      end
   end

   assign left_in = gives_result ? ctr_val : left_ff;

   assign rd_right_addr = col_in + COL_W'(1);

   always_ff @(posedge clock) begin
      if (do_push) begin
         center_mem[col_ff] <= req_bus.pixel_in;
         upper_mem[col_ff]  <= ctr_val;
      end
      ctr_rd_ff   <= center_mem[col_in];
      right_rd_ff <= center_mem[rd_right_addr];
      up_rd_ff    <= upper_mem[col_in];
   end

   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (req_bus.ready) begin
         s1_vld_in = gives_result;
      end
      out_vld_in = out_vld_ff;
      if (out_load) begin
         out_vld_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_vld_in = 1'b0;
      end
   end

   // median by rank, ties broken by position
   always_comb begin
      median = '0;
      for (int i = 0; i < 5; i++) begin
         rank[i] = '0;
         for (int j = 0; j < 5; j++) begin
            if (j < i && s1_op_ff[j] <= s1_op_ff[i]) begin
               rank[i] = rank[i] + 3'd1;
            end else if (j > i && s1_op_ff[j] < s1_op_ff[i]) begin
               rank[i] = rank[i] + 3'd1;
            end
         end
         if (rank[i] == 3'd2) begin
            median = median | s1_op_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         flushing_ff <= 1'b0;
         last_col_ff <= COL_W'(clamp_last(DEFAULT_FRAME_WIDTH, MAX_WIDTH));
         last_row_ff <= ROW_W'(clamp_last(DEFAULT_FRAME_HEIGHT, MAX_HEIGHT));
         wr_vld_ff   <= 1'b0;
         s1_vld_ff   <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         flushing_ff <= flushing_in;
         last_col_ff <= last_col_in;
         last_row_ff <= last_row_in;
         wr_vld_ff   <= do_push;
         s1_vld_ff   <= s1_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff    <= left_in;
      wr_addr_ff <= col_ff;
      wr_pix_ff  <= req_bus.pixel_in;
      wr_ctr_ff  <= ctr_val;
      if (req_bus.ready && gives_result) begin
         s1_op_ff  <= op;
         s1_end_ff <= do_drain && col_last;
      end
      if (out_load) begin
         out_pix_ff <= median;
         out_end_ff <= s1_end_ff;
      end
   end

   assign rsp_bus.valid     = out_vld_ff;
   assign rsp_bus.pixel_out = out_pix_ff;
   assign rsp_bus.frame_end = out_end_ff;

endmodule
